// ===== hw/rtl/brsa_pkg.sv =====
// ----------------------------------------------------------------------------
// brsa_pkg
// Shared types and codes of the binary relation set algebra block.
// ----------------------------------------------------------------------------
package brsa_pkg;

    localparam logic [2:0] OP_CLEAR_A = 3'd0;
    localparam logic [2:0] OP_CLEAR_B = 3'd1;
    localparam logic [2:0] OP_ADD_A   = 3'd2;
    localparam logic [2:0] OP_ADD_B   = 3'd3;
    localparam logic [2:0] OP_COMPUTE = 3'd4;
    localparam logic [2:0] OP_READ    = 3'd5;

    localparam logic [3:0] SET_UNION   = 4'd0;
    localparam logic [3:0] SET_INTER   = 4'd1;
    localparam logic [3:0] SET_COMP_A  = 4'd2;
    localparam logic [3:0] SET_COMP_B  = 4'd3;
    localparam logic [3:0] SET_A_DIFF  = 4'd4;
    localparam logic [3:0] SET_B_DIFF  = 4'd5;
    localparam logic [3:0] SET_SYMDIFF = 4'd6;
    localparam logic [3:0] SET_INV_A   = 4'd7;
    localparam logic [3:0] SET_INV_B   = 4'd8;
    localparam logic [3:0] SET_A_THEN_B = 4'd9;
    localparam logic [3:0] SET_B_THEN_A = 4'd10;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DUP     = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;
    localparam logic [1:0] ST_NO_MORE = 2'd3;

    localparam logic [6:0] DOMAIN_SIZE_RESET = 7'd50;

    typedef struct packed {
        logic [2:0] operation;
        logic [3:0] set_op;
        logic [6:0] pair_first;
        logic [6:0] pair_second;
    } in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] out_first;
        logic [6:0] out_second;
        logic       is_last;
        logic       result_empty;
    } out_t;

endpackage

// ===== hw/rtl/brsa_ram.sv =====
// ----------------------------------------------------------------------------
// brsa_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module brsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/binary_relation_set_algebra.sv =====
// ----------------------------------------------------------------------------
// binary_relation_set_algebra
// Two binary relations and a result relation held as row-wide bit matrices.
// ----------------------------------------------------------------------------
// Each relation is a RAM of DOMAIN rows of DOMAIN bits with one read and one
// write port. A clear works through per-row valid bits, and an add is a
// read-modify-write. An element-wise compute streams one row per cycle.
// An inverse sweeps the operand RAM once for every result row, and a
// composition also fetches the row to expand. A read skips empty result
// rows at one row per cycle. A stalled response holds back the next
// response until it is taken. Each request is answered by exactly one
// response.
module binary_relation_set_algebra #(
    parameter int DOMAIN = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  brsa_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output brsa_pkg::out_t out_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [6:0]     cfg_data
);

    localparam int RW = $clog2(DOMAIN);
    localparam int CW = RW + 1;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ADD     = 4'd1;
    localparam logic [3:0] S_EW      = 4'd2;
    localparam logic [3:0] S_NX_RD   = 4'd3;
    localparam logic [3:0] S_NX_CAP  = 4'd4;
    localparam logic [3:0] S_NIN     = 4'd5;
    localparam logic [3:0] S_NWR     = 4'd6;
    localparam logic [3:0] S_RD_SCAN = 4'd7;
    localparam logic [3:0] S_RD_ROW  = 4'd8;
    localparam logic [3:0] S_RD_LAST = 4'd9;
    localparam logic [3:0] S_FIN     = 4'd10;

    logic [3:0]          state_reg, state_next;
    brsa_pkg::in_t       req_reg, req_next;
    logic [RW-1:0]       add_row_reg, add_row_next;
    logic [RW-1:0]       add_col_reg, add_col_next;
    logic [DOMAIN-1:0]   va_reg, va_next;
    logic [DOMAIN-1:0]   vb_reg, vb_next;
    logic [DOMAIN-1:0]   nz_reg, nz_next;
    logic [6:0]          ds_reg, ds_next;
    logic [CW-1:0]       cur_row_reg, cur_row_next;
    logic [RW-1:0]       cur_col_reg, cur_col_next;
    logic [CW-1:0]       i_reg, i_next;
    logic [CW-1:0]       r_reg, r_next;
    logic                q_v_reg, q_v_next;
    logic [RW-1:0]       q_m_reg, q_m_next;
    logic                rva_reg, rvb_reg;
    logic [DOMAIN-1:0]   xrow_reg, xrow_next;
    logic [DOMAIN-1:0]   acc_reg, acc_next;
    logic [1:0]          pst_reg, pst_next;
    logic [6:0]          pfirst_reg, pfirst_next;
    logic [6:0]          psecond_reg, psecond_next;
    logic                plast_reg, plast_next;
    brsa_pkg::out_t      out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic                a_we, b_we, r_we;
    logic [RW-1:0]       a_waddr, b_waddr, r_waddr;
    logic [DOMAIN-1:0]   a_wdata, b_wdata, r_wdata;
    logic [RW-1:0]       a_raddr, b_raddr, r_raddr;
    logic [DOMAIN-1:0]   a_rdata, b_rdata, r_rdata;
    logic [DOMAIN-1:0]   a_row, b_row;

    logic [8:0]          pf9, ps9, pf_m1, ps_m1, u_w;
    logic                in_range;
    logic [DOMAIN-1:0]   ew_row, masked, rest, y_row, add_row_data;
    logic [RW-1:0]       first_col;
    logic                y_is_a, is_inverse;

    brsa_ram #(.WIDTH(DOMAIN), .DEPTH(DOMAIN)) u_ram_a (
        .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
        .raddr(a_raddr), .rdata(a_rdata)
    );

    brsa_ram #(.WIDTH(DOMAIN), .DEPTH(DOMAIN)) u_ram_b (
        .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
        .raddr(b_raddr), .rdata(b_rdata)
    );

    brsa_ram #(.WIDTH(DOMAIN), .DEPTH(DOMAIN)) u_ram_r (
        .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
        .raddr(r_raddr), .rdata(r_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign a_row = rva_reg ? a_rdata : '0;
    assign b_row = rvb_reg ? b_rdata : '0;

    assign pf9      = {2'b00, in_data.pair_first};
    assign ps9      = {2'b00, in_data.pair_second};
    assign pf_m1    = pf9 - 9'd1;
    assign ps_m1    = ps9 - 9'd1;
    assign in_range = (pf9 >= 9'd1) && (pf9 <= 9'(DOMAIN))
                   && (ps9 >= 9'd1) && (ps9 <= 9'(DOMAIN));
    assign u_w      = ({2'b00, ds_reg} > 9'(DOMAIN)) ? 9'(DOMAIN) : {2'b00, ds_reg};

    assign y_is_a     = (req_reg.set_op == brsa_pkg::SET_INV_A)
                     || (req_reg.set_op == brsa_pkg::SET_B_THEN_A);
    assign is_inverse = (req_reg.set_op == brsa_pkg::SET_INV_A)
                     || (req_reg.set_op == brsa_pkg::SET_INV_B);
    assign y_row      = y_is_a ? a_row : b_row;
    assign add_row_data = (req_reg.operation == brsa_pkg::OP_ADD_A) ? a_row : b_row;

    always_comb
    begin
        logic rin;
        logic cin;
        rin = (9'(q_m_reg) < u_w);
        for (int c = 0; c < DOMAIN; c++)
        begin
            cin = (9'(c) < u_w);
            unique case (req_reg.set_op)
                brsa_pkg::SET_UNION:   ew_row[c] = a_row[c] | b_row[c];
                brsa_pkg::SET_INTER:   ew_row[c] = a_row[c] & b_row[c];
                brsa_pkg::SET_COMP_A:  ew_row[c] = rin & cin & ~a_row[c];
                brsa_pkg::SET_COMP_B:  ew_row[c] = rin & cin & ~b_row[c];
                brsa_pkg::SET_A_DIFF:  ew_row[c] = a_row[c] & ~b_row[c];
                brsa_pkg::SET_B_DIFF:  ew_row[c] = b_row[c] & ~a_row[c];
                brsa_pkg::SET_SYMDIFF: ew_row[c] = a_row[c] ^ b_row[c];
                default:               ew_row[c] = 1'b0;
            endcase
        end
    end

    assign masked = r_rdata & ({DOMAIN{1'b1}} << cur_col_reg);
    assign rest   = masked & (masked - DOMAIN'(1));

    always_comb
    begin
        first_col = '0;
        for (int k = DOMAIN - 1; k >= 0; k--)
        begin
            if (masked[k])
            begin
                first_col = RW'(k);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        add_row_next   = add_row_reg;
        add_col_next   = add_col_reg;
        va_next        = va_reg;
        vb_next        = vb_reg;
        nz_next        = nz_reg;
        ds_next        = ds_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        i_next         = i_reg;
        r_next         = r_reg;
        q_v_next       = q_v_reg;
        q_m_next       = q_m_reg;
        xrow_next      = xrow_reg;
        acc_next       = acc_reg;
        pst_next       = pst_reg;
        pfirst_next    = pfirst_reg;
        psecond_next   = psecond_reg;
        plast_next     = plast_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        a_we = 1'b0;  a_waddr = add_row_reg;  a_wdata = '0;
        b_we = 1'b0;  b_waddr = add_row_reg;  b_wdata = '0;
        r_we = 1'b0;  r_waddr = q_m_reg;      r_wdata = ew_row;
        a_raddr = '0;
        b_raddr = '0;
        r_raddr = cur_row_reg[RW-1:0];

        if (cfg_valid && cfg_ready)
        begin
            ds_next = cfg_data;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next     = in_data;
                    add_row_next = pf_m1[RW-1:0];
                    add_col_next = ps_m1[RW-1:0];
                    pst_next     = brsa_pkg::ST_OK;
                    pfirst_next  = '0;
                    psecond_next = '0;
                    plast_next   = 1'b0;
                    a_raddr      = pf_m1[RW-1:0];
                    b_raddr      = pf_m1[RW-1:0];
                    state_next   = S_FIN;
                    unique case (in_data.operation)
                        brsa_pkg::OP_CLEAR_A: va_next = '0;
                        brsa_pkg::OP_CLEAR_B: vb_next = '0;
                        brsa_pkg::OP_ADD_A, brsa_pkg::OP_ADD_B:
                        begin
                            if (in_range)
                            begin
                                state_next = S_ADD;
                            end
                            else
                            begin
                                pst_next = brsa_pkg::ST_RANGE;
                            end
                        end
                        brsa_pkg::OP_COMPUTE:
                        begin
                            nz_next      = '0;
                            cur_row_next = '0;
                            cur_col_next = '0;
                            i_next       = '0;
                            r_next       = '0;
                            q_v_next     = 1'b0;
                            acc_next     = '0;
                            priority if (in_data.set_op == brsa_pkg::SET_A_THEN_B
                                      || in_data.set_op == brsa_pkg::SET_B_THEN_A)
                            begin
                                state_next = S_NX_RD;
                            end
                            else if (in_data.set_op == brsa_pkg::SET_INV_A
                                  || in_data.set_op == brsa_pkg::SET_INV_B)
                            begin
                                state_next = S_NIN;
                            end
                            else
                            begin
                                state_next = S_EW;
                            end
                        end
                        brsa_pkg::OP_READ: state_next = S_RD_SCAN;
                        default: state_next = S_FIN;
                    endcase
                end
            end

            S_ADD:
            begin
                if (add_row_data[add_col_reg])
                begin
                    pst_next = brsa_pkg::ST_DUP;
                end
                else if (req_reg.operation == brsa_pkg::OP_ADD_A)
                begin
                    a_we    = 1'b1;
                    a_wdata = add_row_data | (DOMAIN'(1) << add_col_reg);
                    va_next[add_row_reg] = 1'b1;
                end
                else
                begin
                    b_we    = 1'b1;
                    b_wdata = add_row_data | (DOMAIN'(1) << add_col_reg);
                    vb_next[add_row_reg] = 1'b1;
                end
                state_next = S_FIN;
            end

            S_EW:
            begin
                a_raddr = i_reg[RW-1:0];
                b_raddr = i_reg[RW-1:0];
                if (i_reg != CW'(DOMAIN))
                begin
                    q_v_next = 1'b1;
                    q_m_next = i_reg[RW-1:0];
                    i_next   = i_reg + CW'(1);
                end
                else
                begin
                    q_v_next = 1'b0;
                end
                if (q_v_reg)
                begin
                    r_we    = 1'b1;
                    r_waddr = q_m_reg;
                    r_wdata = ew_row;
                    nz_next[q_m_reg] = |ew_row;
                end
                if (i_reg == CW'(DOMAIN) && !q_v_reg)
                begin
                    state_next = S_FIN;
                end
            end

            S_NX_RD:
            begin
                a_raddr    = r_reg[RW-1:0];
                b_raddr    = r_reg[RW-1:0];
                state_next = S_NX_CAP;
            end

            S_NX_CAP:
            begin
                xrow_next  = y_is_a ? b_row : a_row;
                acc_next   = '0;
                i_next     = '0;
                q_v_next   = 1'b0;
                state_next = S_NIN;
            end

            S_NIN:
            begin
                a_raddr = i_reg[RW-1:0];
                b_raddr = i_reg[RW-1:0];
                if (i_reg != CW'(DOMAIN))
                begin
                    q_v_next = 1'b1;
                    q_m_next = i_reg[RW-1:0];
                    i_next   = i_reg + CW'(1);
                end
                else
                begin
                    q_v_next = 1'b0;
                end
                if (q_v_reg)
                begin
                    if (is_inverse)
                    begin
                        acc_next[q_m_reg] = y_row[r_reg[RW-1:0]];
                    end
                    else if (xrow_reg[q_m_reg])
                    begin
                        acc_next = acc_reg | y_row;
                    end
                end
                if (i_reg == CW'(DOMAIN) && !q_v_reg)
                begin
                    state_next = S_NWR;
                end
            end

            S_NWR:
            begin
                r_we    = 1'b1;
                r_waddr = r_reg[RW-1:0];
                r_wdata = acc_reg;
                nz_next[r_reg[RW-1:0]] = |acc_reg;
                r_next  = r_reg + CW'(1);
                acc_next = '0;
                i_next   = '0;
                q_v_next = 1'b0;
                priority if (r_reg == CW'(DOMAIN - 1))
                begin
                    state_next = S_FIN;
                end
                else if (is_inverse)
                begin
                    state_next = S_NIN;
                end
                else
                begin
                    state_next = S_NX_RD;
                end
            end

            S_RD_SCAN:
            begin
                priority if (cur_row_reg == CW'(DOMAIN))
                begin
                    cur_col_next = '0;
                    pst_next     = brsa_pkg::ST_NO_MORE;
                    state_next   = S_FIN;
                end
                else if (nz_reg[cur_row_reg[RW-1:0]])
                begin
                    state_next = S_RD_ROW;
                end
                else
                begin
                    cur_row_next = cur_row_reg + CW'(1);
                    cur_col_next = '0;
                end
            end

            S_RD_ROW:
            begin
                if (masked == '0)
                begin
                    cur_row_next = cur_row_reg + CW'(1);
                    cur_col_next = '0;
                    state_next   = S_RD_SCAN;
                end
                else
                begin
                    pfirst_next  = 7'(9'(cur_row_reg) + 9'd1);
                    psecond_next = 7'(9'(first_col) + 9'd1);
                    if (first_col == RW'(DOMAIN - 1))
                    begin
                        cur_row_next = cur_row_reg + CW'(1);
                        cur_col_next = '0;
                    end
                    else
                    begin
                        cur_col_next = first_col + RW'(1);
                    end
                    r_next = cur_row_reg + CW'(1);
                    if (rest != '0)
                    begin
                        plast_next = 1'b0;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_RD_LAST;
                    end
                end
            end

            S_RD_LAST:
            begin
                priority if (r_reg == CW'(DOMAIN))
                begin
                    plast_next = 1'b1;
                    state_next = S_FIN;
                end
                else if (nz_reg[r_reg[RW-1:0]])
                begin
                    plast_next = 1'b0;
                    state_next = S_FIN;
                end
                else
                begin
                    r_next = r_reg + CW'(1);
                end
            end

            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.status       = pst_reg;
                    out_next.out_first    = pfirst_reg;
                    out_next.out_second   = psecond_reg;
                    out_next.is_last      = plast_reg;
                    out_next.result_empty = (nz_reg == '0);
                    out_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            va_reg        <= '0;
            vb_reg        <= '0;
            nz_reg        <= '0;
            ds_reg        <= brsa_pkg::DOMAIN_SIZE_RESET;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            i_reg         <= '0;
            r_reg         <= '0;
            q_v_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            va_reg        <= va_next;
            vb_reg        <= vb_next;
            nz_reg        <= nz_next;
            ds_reg        <= ds_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            i_reg         <= i_next;
            r_reg         <= r_next;
            q_v_reg       <= q_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        add_row_reg <= add_row_next;
        add_col_reg <= add_col_next;
        q_m_reg     <= q_m_next;
        xrow_reg    <= xrow_next;
        acc_reg     <= acc_next;
        pst_reg     <= pst_next;
        pfirst_reg  <= pfirst_next;
        psecond_reg <= psecond_next;
        plast_reg   <= plast_next;
        out_reg     <= out_next;
        rva_reg     <= va_reg[a_raddr];
        rvb_reg     <= vb_reg[b_raddr];
    end

endmodule

// ===== hw/rtl/brsa_checker.sv =====
// ----------------------------------------------------------------------------
// brsa_checker
// Port-level checks of the binary relation set algebra block.
// ----------------------------------------------------------------------------
module brsa_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           out_valid,
    input logic           out_ready,
    input brsa_pkg::out_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("response dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("stalled response changed");

    a_no_pair_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != brsa_pkg::ST_OK
        |-> out_data.out_first == 7'd0 && out_data.out_second == 7'd0
            && !out_data.is_last)
        else $error("pair reported with a failing status");

    a_last_has_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.is_last
        |-> out_data.out_first != 7'd0 && out_data.out_second != 7'd0
            && !out_data.result_empty)
        else $error("last flag without a result pair");

endmodule

bind binary_relation_set_algebra brsa_checker u_brsa_checker (
    .clk(clk),
    .rst_n(rst_n),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
);
